FILE: hdl/gfps_pkg.sv
// Package for the grid flood-fill power scan core: grid and stack sizes,
// state encoding, neighbour result struct and tile index helper. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package gfps_pkg;

  localparam int GRID_WIDTH  = 128;
  localparam int GRID_HEIGHT = 128;
  localparam int STACK_DEPTH = 256;

  localparam int COORD_W    = 7;
  localparam int TILE_COUNT = GRID_WIDTH * GRID_HEIGHT;
  localparam int TILE_W     = $clog2(TILE_COUNT);
  localparam int STACK_W    = $clog2(STACK_DEPTH);
  localparam int VISIT_W    = 24;
  localparam int PLANT_W    = 12;

  localparam logic [VISIT_W-1:0] VISIT_MAX      = '1;
  localparam logic [10:0]        COAL_VISITS    = 11'd700;
  localparam logic [10:0]        NUCLEAR_VISITS = 11'd2000;

  typedef enum logic [1:0] {
    KIND_LOAD = 2'd0,
    KIND_PUSH = 2'd1,
    KIND_SCAN = 2'd2,
    KIND_READ = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    DIR_N = 2'd0,
    DIR_E = 2'd1,
    DIR_S = 2'd2,
    DIR_W = 2'd3
  } dir_t;

  localparam logic CFG_COAL    = 1'b0;
  localparam logic CFG_NUCLEAR = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_POP,
    ST_POP_WAIT,
    ST_STEP,
    ST_PROBE,
    ST_PROBE_WAIT,
    ST_DECIDE,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic               ok;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } nbr_t;

  function automatic logic [TILE_W-1:0] tile_idx(input logic [COORD_W-1:0] x,
                                                 input logic [COORD_W-1:0] y);
    logic [2*TILE_W-1:0] prod;
    prod = TILE_W'(y) * TILE_W'(GRID_WIDTH);
    return prod[TILE_W-1:0] + TILE_W'(x);
  endfunction

  function automatic logic in_grid(input logic [COORD_W-1:0] x,
                                   input logic [COORD_W-1:0] y);
    return ({1'b0, x} < (COORD_W+1)'(GRID_WIDTH)) &&
           ({1'b0, y} < (COORD_W+1)'(GRID_HEIGHT));
  endfunction

endpackage
`default_nettype wire

FILE: hdl/gfps_ram.sv
// Generic single write, single read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module gfps_ram #(
  parameter int DW    = 1,
  parameter int DEPTH = 16384,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: hdl/gfps_nbr.sv
// Shared neighbour unit: coordinate of the cursor's neighbour in one direction
// and whether it lies on the grid. Depends on gfps_pkg.
`timescale 1ns / 1ps
`default_nettype none
module gfps_nbr (
  input  wire logic [gfps_pkg::COORD_W-1:0] cur_x,
  input  wire logic [gfps_pkg::COORD_W-1:0] cur_y,
  input  wire logic [1:0]                   dir,
  output gfps_pkg::nbr_t                    nbr
);

  logic [gfps_pkg::COORD_W:0] x_inc;
  logic [gfps_pkg::COORD_W:0] y_inc;

  always_comb begin
    x_inc = {1'b0, cur_x} + 1'b1;
    y_inc = {1'b0, cur_y} + 1'b1;
    nbr.x  = cur_x;
    nbr.y  = cur_y;
    nbr.ok = 1'b0;
    unique case (dir)
      gfps_pkg::DIR_N: begin
        nbr.ok = (cur_y != '0);
        nbr.y  = cur_y - 1'b1;
      end
      gfps_pkg::DIR_E: begin
        nbr.ok = x_inc < (gfps_pkg::COORD_W+1)'(gfps_pkg::GRID_WIDTH);
        nbr.x  = x_inc[gfps_pkg::COORD_W-1:0];
      end
      gfps_pkg::DIR_S: begin
        nbr.ok = y_inc < (gfps_pkg::COORD_W+1)'(gfps_pkg::GRID_HEIGHT);
        nbr.y  = y_inc[gfps_pkg::COORD_W-1:0];
      end
      default: begin
        nbr.ok = (cur_x != '0);
        nbr.x  = cur_x - 1'b1;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: hdl/grid_flood_fill_power_scan_core.sv
// Flood-fill power scan core. After reset the conductor and powered maps are
// cleared, one tile a cycle, before the first word is taken. Load, push and
// read words pass through the response state before the next accept; a result
// word still waiting holds the input off. A scan word first clears the powered
// map. Each tile visit then passes through a step state, a probe state per
// neighbour and a probe-wait state per on-grid neighbour (probing stops at the
// second hit), and a decide state. Each seed pop passes through the pop and
// pop-wait states; the scan ends in the response state, after the empty-stack
// check in the pop state or on budget exhaustion. Maps have one read port
// each, so probes run one at a time. Depends on gfps_pkg, gfps_ram, gfps_nbr.
`timescale 1ns / 1ps
`default_nettype none
module grid_flood_fill_power_scan_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [11:0] cfg_wdata,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // tile_x[6:0], tile_y[13:7], conductive[14]
  input  wire logic [1:0]  in_tuser,   // kind[1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata   // powered[0], shortage[1], visits[25:2],
                                       // seeds_left[33:26]
);

  localparam int CW = gfps_pkg::COORD_W;
  localparam int TW = gfps_pkg::TILE_W;
  localparam int SW = gfps_pkg::STACK_W;
  localparam int VW = gfps_pkg::VISIT_W;

  gfps_pkg::state_t state_r, state_nxt;

  logic [gfps_pkg::PLANT_W-1:0] coal_r, nuclear_r;
  logic [TW-1:0]  clr_r, clr_nxt;
  logic           init_r, init_nxt;
  logic [SW-1:0]  seed_cnt_r, seed_cnt_nxt;
  logic [CW-1:0]  cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  logic [VW-1:0]  visit_r, visit_nxt, budget_r, budget_nxt;
  logic           short_r, short_nxt;
  logic [1:0]     dir_r, dir_nxt, probe_r, probe_nxt;
  logic           dir_ok_r, dir_ok_nxt;
  logic [1:0]     found_r, found_nxt;
  logic [1:0]     kind_r, kind_nxt;
  logic           rd_ok_r, rd_ok_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [39:0]    out_data_r, out_data_nxt;

  logic [CW-1:0]  in_x, in_y;
  logic           in_cond, accept;
  logic [VW-1:0]  visit_inc;
  logic [22:0]    coal_prod, nuc_prod;

  logic [1:0]           nbr_dir;
  gfps_pkg::nbr_t       nbr;

  logic          cm_we, cm_wd, cm_rd;
  logic [TW-1:0] cm_wa, cm_ra;
  logic          pm_we, pm_wd, pm_rd;
  logic [TW-1:0] pm_wa, pm_ra;
  logic          st_we;
  logic [SW-1:0] st_wa, st_ra;
  logic [2*CW-1:0] st_wd, st_rd;

  assign in_x    = in_tdata[CW-1:0];
  assign in_y    = in_tdata[2*CW-1:CW];
  assign in_cond = in_tdata[2*CW];
  assign in_tready = (state_r == gfps_pkg::ST_IDLE) && (!out_valid_r || out_tready);
  assign accept  = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign visit_inc = (visit_r == gfps_pkg::VISIT_MAX) ? visit_r : visit_r + 1'b1;
  assign coal_prod = 23'(coal_r) * 23'(gfps_pkg::COAL_VISITS);
  assign nuc_prod  = 23'(nuclear_r) * 23'(gfps_pkg::NUCLEAR_VISITS);

  assign nbr_dir = (state_r == gfps_pkg::ST_STEP) ? dir_r : probe_r;

  gfps_nbr u_nbr (
    .cur_x (cur_x_r),
    .cur_y (cur_y_r),
    .dir   (nbr_dir),
    .nbr   (nbr)
  );

  gfps_ram #(.DW(1), .DEPTH(gfps_pkg::TILE_COUNT)) u_cond_map (
    .clk (clk), .we (cm_we), .waddr (cm_wa), .wdata (cm_wd), .raddr (cm_ra), .rdata (cm_rd)
  );

  gfps_ram #(.DW(1), .DEPTH(gfps_pkg::TILE_COUNT)) u_pwr_map (
    .clk (clk), .we (pm_we), .waddr (pm_wa), .wdata (pm_wd), .raddr (pm_ra), .rdata (pm_rd)
  );

  gfps_ram #(.DW(2*CW), .DEPTH(gfps_pkg::STACK_DEPTH)) u_stack (
    .clk (clk), .we (st_we), .waddr (st_wa), .wdata (st_wd), .raddr (st_ra), .rdata (st_rd)
  );

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coal_r    <= '0;
      nuclear_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == gfps_pkg::CFG_COAL) begin
        coal_r <= cfg_wdata;
      end else begin
        nuclear_r <= cfg_wdata;
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      gfps_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = (in_tuser == gfps_pkg::KIND_SCAN) ? gfps_pkg::ST_CLEAR
                                                         : gfps_pkg::ST_RESP;
        end
      end
      gfps_pkg::ST_CLEAR: begin
        if (clr_r == TW'(gfps_pkg::TILE_COUNT - 1)) begin
          state_nxt = init_r ? gfps_pkg::ST_IDLE : gfps_pkg::ST_POP;
        end
      end
      gfps_pkg::ST_POP: begin
        state_nxt = (seed_cnt_r == '0) ? gfps_pkg::ST_RESP : gfps_pkg::ST_POP_WAIT;
      end
      gfps_pkg::ST_POP_WAIT: state_nxt = gfps_pkg::ST_STEP;
      gfps_pkg::ST_STEP: begin
        state_nxt = (visit_inc > budget_r) ? gfps_pkg::ST_RESP : gfps_pkg::ST_PROBE;
      end
      gfps_pkg::ST_PROBE: begin
        if (nbr.ok) begin
          state_nxt = gfps_pkg::ST_PROBE_WAIT;
        end else if (probe_r == gfps_pkg::DIR_W) begin
          state_nxt = gfps_pkg::ST_DECIDE;
        end
      end
      gfps_pkg::ST_PROBE_WAIT: begin
        if ((cm_rd && !pm_rd && found_r == 2'd1) || probe_r == gfps_pkg::DIR_W) begin
          state_nxt = gfps_pkg::ST_DECIDE;
        end else begin
          state_nxt = gfps_pkg::ST_PROBE;
        end
      end
      gfps_pkg::ST_DECIDE: begin
        state_nxt = (found_r != 2'd0) ? gfps_pkg::ST_STEP : gfps_pkg::ST_POP;
      end
      gfps_pkg::ST_RESP: state_nxt = gfps_pkg::ST_IDLE;
      default: state_nxt = gfps_pkg::ST_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    clr_nxt       = clr_r;
    init_nxt      = init_r;
    seed_cnt_nxt  = seed_cnt_r;
    cur_x_nxt     = cur_x_r;
    cur_y_nxt     = cur_y_r;
    visit_nxt     = visit_r;
    budget_nxt    = budget_r;
    short_nxt     = short_r;
    dir_nxt       = dir_r;
    dir_ok_nxt    = dir_ok_r;
    probe_nxt     = probe_r;
    found_nxt     = found_r;
    kind_nxt      = kind_r;
    rd_ok_nxt     = rd_ok_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    cm_we = 1'b0; cm_wa = gfps_pkg::tile_idx(in_x, in_y); cm_wd = in_cond;
    cm_ra = gfps_pkg::tile_idx(nbr.x, nbr.y);
    pm_we = 1'b0; pm_wa = clr_r; pm_wd = 1'b0;
    pm_ra = gfps_pkg::tile_idx(nbr.x, nbr.y);
    st_we = 1'b0; st_wa = seed_cnt_r; st_wd = {in_y, in_x};
    st_ra = seed_cnt_r - 1'b1;
    unique case (state_r)
      gfps_pkg::ST_IDLE: begin
        pm_ra = gfps_pkg::tile_idx(in_x, in_y);
        if (accept) begin
          kind_nxt  = in_tuser;
          rd_ok_nxt = gfps_pkg::in_grid(in_x, in_y);
          unique case (in_tuser)
            gfps_pkg::KIND_LOAD: cm_we = gfps_pkg::in_grid(in_x, in_y);
            gfps_pkg::KIND_PUSH: begin
              if (gfps_pkg::in_grid(in_x, in_y) &&
                  seed_cnt_r < SW'(gfps_pkg::STACK_DEPTH - 1)) begin
                st_we        = 1'b1;
                seed_cnt_nxt = seed_cnt_r + 1'b1;
              end
            end
            gfps_pkg::KIND_SCAN: begin
              clr_nxt    = '0;
              visit_nxt  = '0;
              short_nxt  = 1'b0;
              budget_nxt = VW'(coal_prod) + VW'(nuc_prod);
            end
            default: ;
          endcase
        end
      end
      gfps_pkg::ST_CLEAR: begin
        pm_we = 1'b1;
        cm_we = init_r;
        cm_wa = clr_r;
        cm_wd = 1'b0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == TW'(gfps_pkg::TILE_COUNT - 1)) begin
          init_nxt = 1'b0;
        end
      end
      gfps_pkg::ST_POP: begin
        if (seed_cnt_r != '0) begin
          seed_cnt_nxt = seed_cnt_r - 1'b1;
          dir_ok_nxt   = 1'b0;
        end
      end
      gfps_pkg::ST_POP_WAIT: begin
        cur_x_nxt = st_rd[CW-1:0];
        cur_y_nxt = st_rd[2*CW-1:CW];
      end
      gfps_pkg::ST_STEP: begin
        visit_nxt = visit_inc;
        if (visit_inc > budget_r) begin
          short_nxt = 1'b1;
        end else begin
          pm_we = 1'b1;
          pm_wd = 1'b1;
          pm_wa = gfps_pkg::tile_idx(cur_x_r, cur_y_r);
          if (dir_ok_r && nbr.ok) begin
            cur_x_nxt = nbr.x;
            cur_y_nxt = nbr.y;
            pm_wa     = gfps_pkg::tile_idx(nbr.x, nbr.y);
          end
          found_nxt = 2'd0;
          probe_nxt = gfps_pkg::DIR_N;
        end
      end
      gfps_pkg::ST_PROBE: begin
        if (!nbr.ok) begin
          probe_nxt = probe_r + 1'b1;
        end
      end
      gfps_pkg::ST_PROBE_WAIT: begin
        if (cm_rd && !pm_rd) begin
          found_nxt  = found_r + 1'b1;
          dir_nxt    = probe_r;
          dir_ok_nxt = 1'b1;
        end
        probe_nxt = probe_r + 1'b1;
      end
      gfps_pkg::ST_DECIDE: begin
        st_wd = {cur_y_r, cur_x_r};
        if (found_r == 2'd2 && seed_cnt_r < SW'(gfps_pkg::STACK_DEPTH - 1)) begin
          st_we        = 1'b1;
          seed_cnt_nxt = seed_cnt_r + 1'b1;
        end
      end
      gfps_pkg::ST_RESP: begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = {6'd0, 8'(seed_cnt_r), visit_r, short_r,
                         (kind_r == gfps_pkg::KIND_READ) && rd_ok_r && pm_rd};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gfps_pkg::ST_CLEAR;
      init_r      <= 1'b1;
      clr_r       <= '0;
      seed_cnt_r  <= '0;
      cur_x_r     <= '0;
      cur_y_r     <= '0;
      visit_r     <= '0;
      short_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      init_r      <= init_nxt;
      clr_r       <= clr_nxt;
      seed_cnt_r  <= seed_cnt_nxt;
      cur_x_r     <= cur_x_nxt;
      cur_y_r     <= cur_y_nxt;
      visit_r     <= visit_nxt;
      short_r     <= short_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    budget_r   <= budget_nxt;
    dir_r      <= dir_nxt;
    dir_ok_r   <= dir_ok_nxt;
    probe_r    <= probe_nxt;
    found_r    <= found_nxt;
    kind_r     <= kind_nxt;
    rd_ok_r    <= rd_ok_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
`default_nettype wire

FILE: tb/gfps_checker.sv
// Scoreboard for the flood-fill power scan core: watches config writes and both
// stream channels, predicts each result word and compares it field by field.
// Depends on gfps_pkg.
`timescale 1ns / 1ps
module gfps_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [11:0] cfg_wdata,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,
  output int          fail_count,
  output int          pending
);

  typedef struct {
    logic         powered;
    logic         shortage;
    logic [23:0]  visits;
    logic [7:0]   seeds;
  } status_t;

  status_t status_q[$];

  int unsigned  coal_cnt, nuc_cnt;
  bit           wire_map [gfps_pkg::TILE_COUNT];
  bit           live_map [gfps_pkg::TILE_COUNT];
  logic [6:0]   seed_x [gfps_pkg::STACK_DEPTH];
  logic [6:0]   seed_y [gfps_pkg::STACK_DEPTH];
  int unsigned  seed_cnt;
  int unsigned  cur_x, cur_y;
  logic [23:0]  visit_cnt;
  logic         short_flag;

  task automatic report(input string what, input logic [23:0] got, input logic [23:0] want);
    $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  function automatic void push_seed(input int unsigned x, input int unsigned y);
    if (seed_cnt < gfps_pkg::STACK_DEPTH - 1) begin
      seed_x[seed_cnt] = x[6:0];
      seed_y[seed_cnt] = y[6:0];
      seed_cnt++;
    end
  endfunction

  function automatic bit step_to(input gfps_pkg::dir_t d, output int unsigned nx,
                                 output int unsigned ny);
    nx = cur_x;
    ny = cur_y;
    case (d)
      gfps_pkg::DIR_N: begin if (cur_y == 0) return 0; ny = cur_y - 1; end
      gfps_pkg::DIR_E: begin if (cur_x + 1 >= gfps_pkg::GRID_WIDTH) return 0; nx = cur_x + 1; end
      gfps_pkg::DIR_S: begin if (cur_y + 1 >= gfps_pkg::GRID_HEIGHT) return 0; ny = cur_y + 1; end
      default: begin if (cur_x == 0) return 0; nx = cur_x - 1; end
    endcase
    return 1;
  endfunction

  function automatic void flood_scan();
    int unsigned budget, found, nx, ny, t;
    bit have_dir;
    gfps_pkg::dir_t heading;
    budget = coal_cnt * 700 + nuc_cnt * 2000;
    foreach (live_map[i]) live_map[i] = 0;
    visit_cnt = '0;
    short_flag = 0;
    heading = gfps_pkg::DIR_N;
    while (seed_cnt > 0) begin
      seed_cnt--;
      cur_x = seed_x[seed_cnt];
      cur_y = seed_y[seed_cnt];
      have_dir = 0;
      do begin
        if (visit_cnt != gfps_pkg::VISIT_MAX) visit_cnt++;
        if (visit_cnt > budget) begin
          short_flag = 1;
          return;
        end
        // first step after a pop stays on the seed tile
        if (have_dir && step_to(heading, nx, ny)) begin
          cur_x = nx;
          cur_y = ny;
        end
        live_map[cur_y * gfps_pkg::GRID_WIDTH + cur_x] = 1;
        found = 0;
        for (int d = 0; d < 4 && found < 2; d++) begin
          if (step_to(gfps_pkg::dir_t'(d), nx, ny)) begin
            t = ny * gfps_pkg::GRID_WIDTH + nx;
            if (wire_map[t] && !live_map[t]) begin
              found++;
              heading = gfps_pkg::dir_t'(d);
              have_dir = 1;
            end
          end
        end
        if (found > 1) push_seed(cur_x, cur_y);
      end while (found != 0);
    end
  endfunction

  function automatic void predict(input gfps_pkg::kind_t kind, input int unsigned x,
                                  input int unsigned y, input bit c);
    status_t s;
    s.powered = 0;
    case (kind)
      gfps_pkg::KIND_LOAD: wire_map[y * gfps_pkg::GRID_WIDTH + x] = c;
      gfps_pkg::KIND_PUSH: push_seed(x, y);
      gfps_pkg::KIND_SCAN: flood_scan();
      default:   s.powered = live_map[y * gfps_pkg::GRID_WIDTH + x];
    endcase
    s.shortage = short_flag;
    s.visits = visit_cnt;
    s.seeds = seed_cnt[7:0];
    status_q.push_back(s);
  endfunction

  always @(posedge clk) begin
    status_t want;
    if (!rst_n) begin
      fail_count = 0;
      pending = 0;
      coal_cnt = 0;
      nuc_cnt = 0;
      foreach (wire_map[i]) wire_map[i] = 0;
      foreach (live_map[i]) live_map[i] = 0;
      seed_cnt = 0;
      cur_x = 0;
      cur_y = 0;
      visit_cnt = '0;
      short_flag = 0;
      status_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == gfps_pkg::CFG_COAL) coal_cnt = cfg_wdata;
        else nuc_cnt = cfg_wdata;
      end
      if (in_tvalid && in_tready)
        predict(gfps_pkg::kind_t'(in_tuser), in_tdata[6:0], in_tdata[13:7], in_tdata[14]);
      if (out_tvalid && out_tready) begin
        if (status_q.size() == 0) begin
          report("unexpected result word", '0, '0);
        end else begin
          want = status_q.pop_front();
          if (out_tdata[0] !== want.powered) report("powered", out_tdata[0], want.powered);
          if (out_tdata[1] !== want.shortage) report("shortage", out_tdata[1], want.shortage);
          if (out_tdata[25:2] !== want.visits) report("visits", out_tdata[25:2], want.visits);
          if (out_tdata[33:26] !== want.seeds) report("seeds_left", out_tdata[33:26], want.seeds);
        end
      end
      pending = status_q.size();
    end
  end

endmodule

FILE: tb/tb.sv
// Testbench top for grid_flood_fill_power_scan_core: clock, reset, config and
// stream stimulus with random idling; checking is done in gfps_checker.
// Depends on gfps_pkg, gfps_checker and the core RTL.
`timescale 1ns / 1ps
module tb;

  localparam int IDLE_LIMIT = 200000;

  logic        clk, rst_n;
  logic        cfg_we, cfg_index;
  logic [11:0] cfg_wdata;
  logic        in_tvalid, in_tready;
  logic [15:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid, out_tready;
  logic [39:0] out_tdata;
  int          fail_count, pending;
  int          src_idle_pct, dst_idle_pct;
  int          quiet_cycles;

  grid_flood_fill_power_scan_core uut (.*);

  gfps_checker chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // receiver stalls at random
  always @(negedge clk)
    out_tready <= ($urandom_range(99) >= dst_idle_pct);

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send(input gfps_pkg::kind_t kind, input int unsigned x, input int unsigned y,
                      input bit c);
    while ($urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 0;
      @(negedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= kind;
    in_tdata <= {1'b0, c, y[6:0], x[6:0]};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input int unsigned val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= val[11:0];
    @(negedge clk);
    cfg_we <= 0;
  endtask

  // small region around a random corner: wire it, seed it, scan, look at it
  task automatic region_pass();
    int unsigned bx, by, n;
    bx = $urandom_range(124);
    by = $urandom_range(124);
    n = $urandom_range(8, 3);
    repeat (n) send(gfps_pkg::KIND_LOAD, bx + $urandom_range(3), by + $urandom_range(3),
                    $urandom_range(99) < 80);
    repeat ($urandom_range(2, 1))
      send(gfps_pkg::KIND_PUSH, bx + $urandom_range(3), by + $urandom_range(3), 0);
    send(gfps_pkg::KIND_SCAN, $urandom_range(127), $urandom_range(127), $urandom_range(1));
    repeat (3) send(gfps_pkg::KIND_READ, bx + $urandom_range(3), by + $urandom_range(3), 0);
    // noise
    if ($urandom_range(1))
      send(gfps_pkg::kind_t'($urandom_range(3)), $urandom_range(127), $urandom_range(127),
           $urandom_range(1));
  endtask

  task automatic set_budget(input int unsigned coal, input int unsigned nuc);
    drain();
    write_reg(gfps_pkg::CFG_COAL, coal);
    write_reg(gfps_pkg::CFG_NUCLEAR, nuc);
  endtask

  initial begin
    rst_n = 0;
    cfg_we = 0;
    cfg_index = gfps_pkg::CFG_COAL;
    cfg_wdata = '0;
    in_tvalid = 0;
    in_tdata = '0;
    in_tuser = gfps_pkg::KIND_LOAD;
    out_tready = 0;
    src_idle_pct = 23;
    dst_idle_pct = 82;
    repeat (4) @(negedge clk);
    rst_n <= 1;

    // zero budget: scan stops at once with a shortage
    send(gfps_pkg::KIND_READ, 0, 0, 0);
    send(gfps_pkg::KIND_LOAD, 0, 0, 1);
    send(gfps_pkg::KIND_LOAD, 127, 127, 1);
    send(gfps_pkg::KIND_PUSH, 127, 127, 0);
    send(gfps_pkg::KIND_SCAN, 0, 0, 0);
    send(gfps_pkg::KIND_READ, 127, 127, 0);
    set_budget(1, 0);
    // corner seed with two live neighbours: junction pushes itself back
    send(gfps_pkg::KIND_LOAD, 126, 127, 1);
    send(gfps_pkg::KIND_LOAD, 127, 126, 1);
    send(gfps_pkg::KIND_PUSH, 127, 127, 0);
    send(gfps_pkg::KIND_SCAN, 0, 0, 0);
    send(gfps_pkg::KIND_READ, 126, 127, 0);
    send(gfps_pkg::KIND_READ, 127, 126, 0);
    send(gfps_pkg::KIND_READ, 127, 127, 0);
    // seed on a non-conductive tile still gets marked
    send(gfps_pkg::KIND_PUSH, 0, 5, 0);
    send(gfps_pkg::KIND_LOAD, 1, 0, 1);
    send(gfps_pkg::KIND_PUSH, 0, 0, 0);
    send(gfps_pkg::KIND_SCAN, 0, 0, 1);
    send(gfps_pkg::KIND_READ, 0, 5, 0);
    send(gfps_pkg::KIND_READ, 1, 0, 0);
    set_budget(4095, 4095);
    send(gfps_pkg::KIND_LOAD, 127, 127, 0);
    send(gfps_pkg::KIND_PUSH, 127, 126, 0);
    send(gfps_pkg::KIND_SCAN, 0, 0, 0);
    send(gfps_pkg::KIND_READ, 126, 127, 0);

    repeat (2) region_pass();
    // a pile of seeds, then scan on a tight budget
    repeat (12) send(gfps_pkg::KIND_PUSH, $urandom_range(127), $urandom_range(127), 0);
    set_budget(0, 1);
    send(gfps_pkg::KIND_SCAN, 0, 0, 0);
    send(gfps_pkg::KIND_READ, $urandom_range(127), $urandom_range(127), 0);

    src_idle_pct = 82;
    dst_idle_pct = 23;
    set_budget($urandom_range(3), $urandom_range(1));
    region_pass();
    set_budget(4095, 0);
    region_pass();

    src_idle_pct = 0;
    dst_idle_pct = 0;
    set_budget(0, $urandom_range(4095));
    region_pass();
    set_budget($urandom_range(2), 0);
    region_pass();

    drain();
    repeat (50) @(negedge clk);
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
